>>> rtl/core/lfu_pkg.sv
// Package for the LFU key cache: controller state type, the command and status
// groups between controller and datapath, and the field widths. No dependencies.
package lfu_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned STAMP_W = 32;

endpackage

>>> rtl/core/lfu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lfu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lfu_ctrl.sv
// Controller state machine for the LFU key cache: accept, scan, commit.
// Depends on lfu_pkg.
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.start  = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan   = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd      = '0;
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/lfu_dp.sv
// Datapath for the LFU key cache: entry memories, scan pipeline, victim
// tracking, update and output register. Depends on lfu_pkg and lfu_ram.
module lfu_dp
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [KEY_W-1:0]   i_request_key,
    input  logic               i_in_dictionary,
    input  logic [VALUE_W-1:0] i_dictionary_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [VALUE_W-1:0] o_hit_value,
    output logic               o_inserted,
    output logic               o_evict_valid,
    output logic [KEY_W-1:0]   o_evicted_key
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]   r_key;
    logic               r_dict;
    logic [VALUE_W-1:0] r_dval;

    logic [CW-1:0]      r_occ;
    logic [STAMP_W-1:0] r_next_stamp;

    logic [CW-1:0]      r_issue_idx;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;

    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [VALUE_W-1:0] r_hit_val;
    logic [COUNT_W-1:0] r_hit_cnt;

    logic               r_best_vld;
    logic [IW-1:0]      r_best_idx;
    logic [COUNT_W-1:0] r_best_cnt;
    logic [STAMP_W-1:0] r_best_age;
    logic [KEY_W-1:0]   r_best_key;

    logic               r_out_valid;
    logic               r_out_hit;
    logic [VALUE_W-1:0] r_out_hit_value;
    logic               r_out_inserted;
    logic               r_out_evict;
    logic [KEY_W-1:0]   r_out_evicted_key;

    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    logic [COUNT_W-1:0] rd_count;
    logic [STAMP_W-1:0] rd_stamp;

    logic               issue_en;
    logic [STAMP_W-1:0] age;
    logic               better;
    logic               full;
    logic               do_ins;
    logic               evict;
    logic [IW-1:0]      slot;
    logic               we_ins;
    logic               we_cnt;
    logic [IW-1:0]      cnt_addr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_sat;
    logic               out_free;

    assign issue_en = i_cmd.scan && (r_issue_idx < r_occ);
    assign age      = r_next_stamp - rd_stamp;
    assign better   = !r_best_vld || (rd_count < r_best_cnt) ||
                      ((rd_count == r_best_cnt) && (age > r_best_age));

    assign full     = (r_occ == CW'(ENTRIES));
    assign do_ins   = !r_hit && r_dict;
    assign evict    = do_ins && full;
    assign slot     = full ? r_best_idx : r_occ[IW-1:0];
    assign cnt_sat  = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + COUNT_W'(1);
    assign we_ins   = i_cmd.commit && do_ins;
    assign we_cnt   = i_cmd.commit && (r_hit || do_ins);
    assign cnt_addr = r_hit ? r_hit_idx : slot;
    assign cnt_wdata = r_hit ? cnt_sat : COUNT_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.scan_done = (r_issue_idx >= r_occ) && !r_cmp_vld;
    assign o_status.out_free  = out_free;

    lfu_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we_ins),
        .i_waddr (slot),
        .i_wdata (r_key),
        .i_raddr (r_issue_idx[IW-1:0]),
        .o_rdata (rd_key)
    );

    lfu_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (we_ins),
        .i_waddr (slot),
        .i_wdata (r_dval),
        .i_raddr (r_issue_idx[IW-1:0]),
        .o_rdata (rd_value)
    );

    lfu_ram #(.WIDTH(COUNT_W), .DEPTH(ENTRIES)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (we_cnt),
        .i_waddr (cnt_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_issue_idx[IW-1:0]),
        .o_rdata (rd_count)
    );

    lfu_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (we_ins),
        .i_waddr (slot),
        .i_wdata (r_next_stamp),
        .i_raddr (r_issue_idx[IW-1:0]),
        .o_rdata (rd_stamp)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= i_request_key;
            r_dict <= i_in_dictionary;
            r_dval <= i_dictionary_value;
        end
        if (issue_en) begin
            r_cmp_idx <= r_issue_idx[IW-1:0];
        end
        if (r_cmp_vld && (rd_key == r_key)) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_val <= rd_value;
            r_hit_cnt <= rd_count;
        end
        if (r_cmp_vld && better) begin
            r_best_idx <= r_cmp_idx;
            r_best_cnt <= rd_count;
            r_best_age <= age;
            r_best_key <= rd_key;
        end
        if (i_cmd.commit) begin
            r_out_hit         <= r_hit;
            r_out_hit_value   <= r_hit ? r_hit_val : '0;
            r_out_inserted    <= do_ins;
            r_out_evict       <= evict;
            r_out_evicted_key <= evict ? r_best_key : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ        <= '0;
            r_next_stamp <= '0;
            r_issue_idx  <= '0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_best_vld   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cmp_vld <= issue_en;
            if (i_cmd.start) begin
                r_issue_idx <= '0;
                r_hit       <= 1'b0;
                r_best_vld  <= 1'b0;
            end else begin
                if (issue_en) begin
                    r_issue_idx <= r_issue_idx + CW'(1);
                end
                if (r_cmp_vld && (rd_key == r_key)) begin
                    r_hit <= 1'b1;
                end
                if (r_cmp_vld) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (we_ins) begin
                r_next_stamp <= r_next_stamp + STAMP_W'(1);
                if (!full) begin
                    r_occ <= r_occ + CW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_hit_value   = r_out_hit_value;
    assign o_inserted    = r_out_inserted;
    assign o_evict_valid = r_out_evict;
    assign o_evicted_key = r_out_evicted_key;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(ENTRIES))
        else $error("occupancy above capacity");

    a_hit_no_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_hit |=> $stable(r_occ) && $stable(r_next_stamp))
        else $error("hit changed occupancy or stamp");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && evict |-> r_best_vld)
        else $error("eviction without a victim");

    a_evict_inserts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_evict |-> r_out_inserted && !r_out_hit)
        else $error("eviction without insertion");

endmodule

>>> rtl/core/lfu_key_cache_top.sv
// Each input transaction is accepted in idle, then scanned and committed; the input is
// stalled until the commit, so a new transaction is not taken before the last is through.
// The scan reads one entry per cycle through each memory read port.
// A finished result waits in the output register while the next one is taken.
// Reset: synchronous, active low; clears occupancy, stamp counter and control;
// entry memories are not cleared, only entries below the occupancy are read.
module lfu_key_cache_top
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [KEY_W-1:0]   i_request_key,
    input  logic               i_in_dictionary,
    input  logic [VALUE_W-1:0] i_dictionary_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [VALUE_W-1:0] o_hit_value,
    output logic               o_inserted,
    output logic               o_evict_valid,
    output logic [KEY_W-1:0]   o_evicted_key
);

    t_cmd    cmd;
    t_status status;

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfu_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_request_key      (i_request_key),
        .i_in_dictionary    (i_in_dictionary),
        .i_dictionary_value (i_dictionary_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_hit_value        (o_hit_value),
        .o_inserted         (o_inserted),
        .o_evict_valid      (o_evict_valid),
        .o_evicted_key      (o_evicted_key)
    );

endmodule
